/* hdl/sust_pkg.sv */
// Shared types and constants of the sorted unique set table.
// Holds the request and status codes and the per-cell control struct.
// No dependencies.
package sust_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DELETED   = 3'd5
    } t_status;

    localparam int KEY_W  = 32;
    localparam int SIZE_W = 7;

    // Update command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

/* hdl/sust_cell.sv */
// One cell of the sorted key chain: holds the key at its own position.
// Compares against the broadcast key and shifts with its neighbors.
// Depends on sust_pkg.
module sust_cell
    import sust_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                     i_clk,
    input  logic [CW-1:0]            i_count,
    input  logic signed [KEY_W-1:0]  i_key,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_left_lt,
    input  logic signed [KEY_W-1:0]  i_left_key,
    input  logic signed [KEY_W-1:0]  i_right_key,
    output logic signed [KEY_W-1:0]  o_key,
    output logic                     o_lt,
    output logic                     o_eq
);

    logic                    w_valid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    assign w_valid = (CW'(IDX) < i_count);
    assign o_lt    = w_valid && (r_key < i_key);
    assign o_eq    = w_valid && (r_key == i_key);
    assign o_key   = r_key;

    // Cells below the target position keep their key; the rest move one place.
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !o_lt) begin
            n_key = i_left_lt ? i_key : i_left_key;
        end else if (i_ctl.del && !o_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* hdl/sorted_unique_set_table.sv */
// Top level of the sorted unique set table: request control and cell chain.
// Depends on sust_pkg and sust_cell.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_req_type, i_key
// result    out        o_valid strobe, 1 cycle   o_status, o_set_size
//
// For each item, the accepting edge latches the request, and in the
// next cycle every cell compares its key and the whole chain shifts at once.
// busy is high for that one cycle, so a new item can start only once busy is low.
// The result is registered together with the update; the receiver cannot stall.
// Reset empties the set by clearing the count; key storage needs no clearing.
module sorted_unique_set_table
    import sust_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_req_type,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [SIZE_W-1:0]       o_set_size
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    r_busy;
    logic [1:0]              r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_valid;
    t_status                 r_status;
    t_status                 n_status;

    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic signed [KEY_W-1:0] w_keys [CAPACITY];
    logic                    w_held;
    logic                    w_full;
    t_cell_ctl               w_ctl;

    assign w_held = |w_eq;
    assign w_full = (r_count == CW'(CAPACITY));

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = ST_NOT_FOUND;
        case (t_req'(r_op))
            REQ_INSERT: begin
                if (w_held) begin
                    n_status = ST_DUPLICATE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status  = ST_INSERTED;
                    w_ctl.ins = r_busy;
                    n_count   = r_count + CW'(1);
                end
            end
            REQ_SEARCH: begin
                n_status = w_held ? ST_FOUND : ST_NOT_FOUND;
            end
            REQ_DELETE: begin
                if (w_held) begin
                    n_status  = ST_DELETED;
                    w_ctl.del = r_busy;
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                    w_left_lt;
            logic signed [KEY_W-1:0] w_left_key;
            logic signed [KEY_W-1:0] w_right_key;
            if (gi == 0) begin : g_first
                assign w_left_lt  = 1'b1;
                assign w_left_key = r_key;
            end else begin : g_inner
                assign w_left_lt  = w_lt[gi-1];
                assign w_left_key = w_keys[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_key = w_keys[gi];
            end else begin : g_mid
                assign w_right_key = w_keys[gi+1];
            end
            sust_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_count     (r_count),
                .i_key       (r_key),
                .i_ctl       (w_ctl),
                .i_left_lt   (w_left_lt),
                .i_left_key  (w_left_key),
                .i_right_key (w_right_key),
                .o_key       (w_keys[gi]),
                .o_lt        (w_lt[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_status <= ST_NOT_FOUND;
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_busy   <= 1'b0;
                r_count  <= n_count;
                r_status <= n_status;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_op  <= i_req_type;
            r_key <= i_key;
        end
    end

    assign busy       = r_busy;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_set_size = SIZE_W'(r_count);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("key count exceeds capacity");

    // Every accepted item gives its result, registered with the chain update.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing after accepted item");

    // An inserted key raises the count by exactly one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_INSERTED) |-> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the set by one");

    // A delete or a duplicate is only reported when the key matched a cell.
    a_match_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (n_status == ST_DELETED || n_status == ST_DUPLICATE)) |-> w_held)
        else $error("match status without a matching cell");

endmodule
